/* rtl/core/gwm_pkg.sv */
// Package for the glob matcher: item types, operation codes and pattern constants.
package gwm_pkg;

  localparam int unsigned GWM_PATTERN_MAX = 63;

  localparam logic [7:0] GWM_STAR_CODE = 8'd42;
  localparam logic [7:0] GWM_ANY_CODE  = 8'd63;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_SUBJECT = 2'd2;
  localparam logic [1:0] OP_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic       last;
  } gwm_in_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } gwm_out_t;

endpackage

/* rtl/core/glob_wildcard_matcher_unit.sv */
// Glob matcher top level: row of position cells, star closure, verdict output stage.
// Throughput: one item per cycle while the skid slot is empty, any mix of pattern,
// subject and empty-subject items. The rate is set by the combinational live vector
// update: byte compare in every cell, then one carry chain add across PATTERN_MAX+1
// positions for the star closure. Reset (async, active low) clears length, overflow,
// live vector and output stage; pattern bytes are not reset and are only read below
// the current length.
module glob_wildcard_matcher_unit import gwm_pkg::*; #(
  parameter int unsigned PATTERN_MAX = GWM_PATTERN_MAX
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gwm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gwm_out_t out_data_o
);

  localparam int unsigned W    = PATTERN_MAX + 1;
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);

  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            inside_q, inside_d;
  logic            all_star_q, all_star_d;
  logic [W-1:0]    live_q, live_d;
  logic [W-1:0]    init_q, init_d;

  logic            in_fire, full, append_ok, produce;
  logic [W-1:0]    end_onehot, above_len;
  logic [PATTERN_MAX-1:0] active, wr_en, star, stay, step;
  logic [W-1:0]    src, nv, smask, gen, sum, closed;
  logic            hit;
  gwm_out_t        res;

  logic            out_valid_q, skid_valid_q;
  gwm_out_t        out_q, skid_q;

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign full       = (len_q == LenW'(PATTERN_MAX));
  assign append_ok  = in_fire & (in_data_i.operation == OP_APPEND) & ~full;

  always_comb begin
    for (int k = 0; k < W; k++) begin
      end_onehot[k] = (len_q == LenW'(k));
      above_len[k]  = (LenW'(k) > len_q);
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      active[i] = (LenW'(i) < len_q);
      wr_en[i]  = append_ok & end_onehot[i];
    end
  end

  assign src = inside_q ? live_q : init_q;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    gwm_cell u_cell (
      .clk_i       (clk_i),
      .wr_en_i     (wr_en[g]),
      .wr_char_i   (in_data_i.char_code),
      .subj_char_i (in_data_i.char_code),
      .live_i      (src[g]),
      .active_i    (active[g]),
      .star_o      (star[g]),
      .stay_o      (stay[g]),
      .step_o      (step[g])
    );
  end

  assign nv    = {1'b0, stay} | {step, 1'b0};
  assign smask = {1'b0, star};
  assign gen   = nv & smask;
  // closure over star runs is a carry chain: stars propagate, live stars generate
  assign sum    = smask + gen;
  assign closed = nv | (sum ^ smask ^ gen);

  always_comb begin
    len_d      = len_q;
    ovf_d      = ovf_q;
    inside_d   = inside_q;
    all_star_d = all_star_q;
    live_d     = live_q;
    init_d     = init_q;
    produce    = 1'b0;
    hit        = 1'b0;
    if (in_fire) begin
      case (in_data_i.operation)
        OP_CLEAR: begin
          len_d      = '0;
          ovf_d      = 1'b0;
          inside_d   = 1'b0;
          all_star_d = 1'b1;
          live_d     = '0;
          init_d     = W'(1);
        end
        OP_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
            if (all_star_q && (in_data_i.char_code == GWM_STAR_CODE)) begin
              init_d = init_q | (end_onehot << 1);
            end else begin
              all_star_d = 1'b0;
            end
          end
          live_d   = '0;
          inside_d = 1'b0;
        end
        OP_SUBJECT: begin
          live_d   = closed;
          inside_d = ~in_data_i.last;
          produce  = in_data_i.last;
          hit      = |(closed & end_onehot);
        end
        default: begin
          // empty subject: only the all-star pattern reaches its end
          inside_d = 1'b0;
          live_d   = init_q;
          produce  = 1'b1;
          hit      = all_star_q;
        end
      endcase
    end
  end

  assign res.matched          = hit & ~ovf_q;
  assign res.pattern_overflow = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      ovf_q      <= 1'b0;
      inside_q   <= 1'b0;
      all_star_q <= 1'b1;
      live_q     <= '0;
      init_q     <= W'(1);
    end else begin
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      inside_q   <= inside_d;
      all_star_q <= all_star_d;
      live_q     <= live_d;
      init_q     <= init_d;
    end
  end

  // output register plus skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_ready_i) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= produce;
        end
      end else if (produce) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (produce) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full while output slot empty");

  a_ovf_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> full)
    else $error("overflow flag set below capacity");

  a_live_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q & above_len) == '0)
    else $error("live position beyond pattern length");

  a_all_star_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_star_q |-> (|(init_q & end_onehot)))
    else $error("all-star pattern start vector misses its end");

  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pattern_overflow) |-> !out_data_o.matched)
    else $error("match reported under overflow");
`endif

endmodule

/* rtl/core/gwm_cell.sv */
// One pattern position: holds its pattern byte and advances its live bit over a subject byte.
module gwm_cell import gwm_pkg::*; (
  input  logic       clk_i,
  input  logic       wr_en_i,
  input  logic [7:0] wr_char_i,
  input  logic [7:0] subj_char_i,
  input  logic       live_i,
  input  logic       active_i,
  output logic       star_o,
  output logic       stay_o,
  output logic       step_o
);

  logic [7:0] pat_q;
  logic       is_star;
  logic       hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pat_q <= wr_char_i;
    end
  end

  assign is_star = (pat_q == GWM_STAR_CODE);
  assign hit     = (pat_q == GWM_ANY_CODE) || (pat_q == subj_char_i);

  assign star_o = active_i & is_star;
  // a star keeps its own position; a literal or '?' hands the bit to the next cell
  assign stay_o = active_i & live_i & is_star;
  assign step_o = active_i & live_i & ~is_star & hit;

endmodule

/* sim/tb_glob_wildcard_matcher_unit.sv */
// Testbench for the glob matcher: directed, capacity, stall and random item streams.
module tb_glob_wildcard_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gwm_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int CALM_ITEMS   = 50;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 10;

  typedef logic [7:0] char_queue_t[$];

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  gwm_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  gwm_out_t out_data_o;

  // stimulus control
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_req = 1'b0;
  int          items_sent = 0;
  int          mismatch_count = 0;
  char_queue_t gen_pat;

  // predictor state
  logic [7:0]  pat_mem [GWM_PATTERN_MAX];
  int unsigned pat_len = 0;
  logic [63:0] live_vec = '0;
  bit          in_subject = 1'b0;
  bit          overflowed = 1'b0;
  gwm_out_t    verdict_q[$];
  gwm_out_t    expected_v;

  glob_wildcard_matcher_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Star runs propagate in order, so a chain of stars closes in one pass.
  function automatic logic [63:0] star_close(logic [63:0] v);
    for (int i = 0; i < pat_len; i++) begin
      if (v[i] && pat_mem[i] == GWM_STAR_CODE) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [63:0] step_live(logic [63:0] v, logic [7:0] c);
    logic [63:0] nv;
    nv = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (v[i]) begin
        if (pat_mem[i] == GWM_STAR_CODE) nv[i] = 1'b1;
        else if (pat_mem[i] == GWM_ANY_CODE || pat_mem[i] == c) nv[i+1] = 1'b1;
      end
    end
    return star_close(nv);
  endfunction

  function automatic void push_verdict();
    gwm_out_t v;
    v.matched          = !overflowed && live_vec[pat_len];
    v.pattern_overflow = overflowed;
    verdict_q.push_back(v);
  endfunction

  function automatic void apply_glob_item(gwm_in_t it);
    case (it.operation)
      OP_CLEAR: begin
        pat_len    = 0;
        overflowed = 1'b0;
        live_vec   = '0;
        in_subject = 1'b0;
      end
      OP_APPEND: begin
        if (pat_len < GWM_PATTERN_MAX) begin
          pat_mem[pat_len] = it.char_code;
          pat_len++;
        end else begin
          overflowed = 1'b1;
        end
        live_vec   = '0;
        in_subject = 1'b0;
      end
      OP_SUBJECT: begin
        if (!in_subject) begin
          live_vec   = star_close(64'd1);
          in_subject = 1'b1;
        end
        live_vec = step_live(live_vec, it.char_code);
        if (it.last) begin
          in_subject = 1'b0;
          push_verdict();
        end
      end
      default: begin
        in_subject = 1'b0;
        live_vec   = star_close(64'd1);
        push_verdict();
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Inputs are folded into the predictor before the output is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) apply_glob_item(in_data_i);
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with none pending");
        end else begin
          expected_v = verdict_q.pop_front();
          if (out_data_o.matched !== expected_v.matched)
            report_mismatch($sformatf("matched got %b want %b",
                                      out_data_o.matched, expected_v.matched));
          if (out_data_o.pattern_overflow !== expected_v.pattern_overflow)
            report_mismatch($sformatf("pattern_overflow got %b want %b",
                                      out_data_o.pattern_overflow,
                                      expected_v.pattern_overflow));
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  always begin
    @(negedge clk_i);
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      out_ready_i <= 1'b1;
      hold_req = 1'b0;
    end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic last);
    gwm_in_t it;
    it.operation = op;
    it.char_code = ch;
    it.last      = last;
    @(negedge clk_i);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pat_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return GWM_STAR_CODE;
      3, 4:    return GWM_ANY_CODE;
      9:       return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 2));
    endcase
  endfunction

  // Builds a subject that fits the pattern, then sometimes damages it.
  function automatic char_queue_t make_subject(char_queue_t pat);
    char_queue_t s;
    int          k;
    foreach (pat[i]) begin
      if (pat[i] == GWM_STAR_CODE) repeat ($urandom_range(0, 3)) s.push_back(rand_char());
      else if (pat[i] == GWM_ANY_CODE) s.push_back(rand_char());
      else s.push_back(pat[i]);
    end
    case ($urandom_range(0, 5))
      0: if (s.size() > 0) begin
        k = $urandom_range(0, s.size() - 1);
        s[k] = rand_char();
      end
      1: if (s.size() > 0) s.delete($urandom_range(0, s.size() - 1));
      2: s.insert($urandom_range(0, s.size()), rand_char());
      default: ;
    endcase
    return s;
  endfunction

  task automatic load_pattern(input char_queue_t pat);
    foreach (pat[i]) begin
      send_item(OP_APPEND, pat[i], 1'($urandom_range(0, 1)));
      if (gen_pat.size() < GWM_PATTERN_MAX) gen_pat.push_back(pat[i]);
    end
  endtask

  task automatic clear_pattern();
    send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    gen_pat.delete();
  endtask

  task automatic send_subject(input char_queue_t s);
    if (s.size() == 0) begin
      send_item(OP_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      foreach (s[i]) send_item(OP_SUBJECT, s[i], i == s.size() - 1);
    end
  endtask

  task automatic test_directed();
    char_queue_t s;
    send_item(OP_EMPTY, 8'h00, 1'b0);        // empty pattern, empty string
    send_item(OP_SUBJECT, 8'hFF, 1'b1);      // empty pattern, one byte
    send_item(OP_CLEAR, 8'hFF, 1'b1);
    gen_pat.delete();
    s = '{GWM_STAR_CODE};
    load_pattern(s);
    send_item(OP_EMPTY, 8'hFF, 1'b1);
    s = '{8'h00, 8'hFF};
    send_subject(s);
    s = '{GWM_ANY_CODE};
    load_pattern(s);
    send_item(OP_SUBJECT, 8'h00, 1'b1);
    send_item(OP_EMPTY, 8'h00, 1'b1);        // "*?" needs one byte
    clear_pattern();
    s = '{8'h00, GWM_ANY_CODE, 8'hFF};
    load_pattern(s);
    s = '{8'h00, 8'h55, 8'hFF};
    send_subject(s);
    s = '{8'h00, 8'hFF};
    send_subject(s);
    // append in the middle of a subject drops that subject
    send_item(OP_SUBJECT, 8'h00, 1'b0);
    s = '{GWM_STAR_CODE};
    load_pattern(s);
    s = '{8'h00, 8'hAA, 8'hFF};
    send_subject(s);
    send_item(OP_SUBJECT, GWM_STAR_CODE, 1'b1);  // star is a plain byte in a subject
  endtask

  task automatic test_pattern_capacity();
    char_queue_t pat;
    char_queue_t subj;
    clear_pattern();
    pat.push_back(GWM_STAR_CODE);
    repeat (GWM_PATTERN_MAX - 1) pat.push_back(GWM_ANY_CODE);
    load_pattern(pat);
    repeat (GWM_PATTERN_MAX - 1) subj.push_back(8'($urandom_range(0, 255)));
    send_subject(subj);                      // reaches the top position
    void'(subj.pop_back());
    send_subject(subj);                      // one byte short
    pat = '{8'h78, GWM_STAR_CODE};
    load_pattern(pat);                       // full: dropped, overflow
    send_subject(subj);
    send_item(OP_EMPTY, 8'hFF, 1'b1);
    clear_pattern();
    send_item(OP_EMPTY, 8'h00, 1'b0);
  endtask

  task automatic test_output_stall();
    char_queue_t pat;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    clear_pattern();
    pat = '{8'h61, GWM_STAR_CODE};
    load_pattern(pat);
    hold_req = 1'b1;
    repeat (40) begin
      send_item(OP_EMPTY, rand_char(), 1'b0);
      send_item(OP_SUBJECT, rand_char(), 1'b1);
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_random_sequences();
    char_queue_t pat;
    char_queue_t subj;
    int          start;
    int          n;
    bit          dirty;
    start = items_sent;
    dirty = 1'b0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start >= RANDOM_ITEMS - CALM_ITEMS) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else begin
        tx_gaps = $urandom_range(0, 3) != 0;
        rx_gaps = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: any operation, any fields
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        dirty = 1'b1;
      end else begin
        if (dirty || $urandom_range(0, 4) != 0) begin
          clear_pattern();
          dirty = 1'b0;
        end
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(55, 66) : $urandom_range(0, 8);
        pat.delete();
        repeat (n) pat.push_back(pat_char());
        load_pattern(pat);
        repeat ($urandom_range(1, 4)) begin
          subj = make_subject(gen_pat);
          if ($urandom_range(0, 7) == 0 && subj.size() > 1) begin
            // unterminated subject: the next one continues it
            for (int k = 0; k < subj.size() - 1; k++) send_item(OP_SUBJECT, subj[k], 1'b0);
          end else begin
            send_subject(subj);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_pattern_capacity();
    test_output_stall();
    test_random_sequences();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
